>>> src/nnis_pkg.sv
// Shared types, codes and the divider step of the nearest-neighbor image scaler.
`timescale 1ns / 1ps

package nnis_pkg;

	// Operation codes carried by the opcode field.
	localparam logic OP_WRITE   = 1'b0;
	localparam logic OP_REQUEST = 1'b1;

	// Register indexes on the configuration port.
	localparam logic [1:0] REG_SRC_WIDTH  = 2'd0;
	localparam logic [1:0] REG_SRC_HEIGHT = 2'd1;
	localparam logic [1:0] REG_DST_WIDTH  = 2'd2;
	localparam logic [1:0] REG_DST_HEIGHT = 2'd3;

	// Register and coordinate widths fixed by the interface.
	localparam int REG_W   = 9;
	localparam int COORD_W = 8;
	localparam int PIX_W   = 24;

	// Divider sizes: numerator (2d+1)*(n-1)+dn fits 19 bits, divisor 2*dn fits 10 bits.
	localparam int NUM_W = 19;
	localparam int DIV_W = 10;
	localparam int CNT_W = 5;

	// State of one restoring divider lane; num shifts out dividend bits and in quotient bits.
	typedef struct packed {
		logic [NUM_W-1:0] num;
		logic [DIV_W-1:0] rem;
		logic [DIV_W-1:0] div;
	} div_lane_t;

	// One restoring division step: one quotient bit per call.
	function automatic div_lane_t div_step(input div_lane_t lane);
		logic [DIV_W:0] shifted;
		logic [DIV_W:0] diff;
		div_lane_t      nxt;
		shifted = {lane.rem, lane.num[NUM_W-1]};
		diff    = shifted - {1'b0, lane.div};
		nxt     = lane;
		if (shifted >= {1'b0, lane.div}) begin
			nxt.rem = diff[DIV_W-1:0];
			nxt.num = {lane.num[NUM_W-2:0], 1'b1};
		end else begin
			nxt.rem = shifted[DIV_W-1:0];
			nxt.num = {lane.num[NUM_W-2:0], 1'b0};
		end
		return nxt;
	endfunction

endpackage

>>> src/nearest_neighbour_image_scaler.sv
// Nearest-neighbor image scaler: frame store, coordinate mapping and APB registers.
//
// Usage: a command word is taken at a rising edge where start is high and busy is low.
// Opcode write stores (pix_blue, pix_green, pix_red) at (src_x, src_y) in the frame
// store and produces no result; busy stays low.
// Opcode request asks for destination pixel (dst_x, dst_y). A request outside the
// destination size answers in the next cycle with zeros and out_of_range set. A
// request inside the size maps both coordinates to source coordinates with two
// restoring dividers running side by side, one quotient bit per cycle, through a
// multiply state, a divide state and a frame-store read state; busy stays high until
// the result word appears, and a new word can be taken in the cycle it is shown.
// Each result word is marked by done, high for exactly one cycle; the receiver
// cannot stall, so done is never held. Registers (src_width, src_height, dst_width,
// dst_height) sit at byte addresses 0, 4, 8 and 12 of the APB port; the user must
// write them only while the block is idle, and the block itself does not enforce
// this. Reset sets all four registers to 256 and returns the sequencer to idle; the
// frame store is not cleared and holds undefined data until written.
`timescale 1ns / 1ps

module nearest_neighbour_image_scaler
	import nnis_pkg::*;
#(
	parameter int MAX_WIDTH  = 256,
	parameter int MAX_HEIGHT = 256
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// Command channel
	input  logic                 start,
	output logic                 busy,
	input  logic                 opcode,
	input  logic [COORD_W-1:0]   src_x,
	input  logic [COORD_W-1:0]   src_y,
	input  logic [7:0]           pix_blue,
	input  logic [7:0]           pix_green,
	input  logic [7:0]           pix_red,
	input  logic [COORD_W-1:0]   dst_x,
	input  logic [COORD_W-1:0]   dst_y,
	// Result channel
	output logic                 done,
	output logic [7:0]           out_blue,
	output logic [7:0]           out_green,
	output logic [7:0]           out_red,
	output logic                 out_of_range,
	// Configuration port
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [3:0]           paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready
);

	// Frame store geometry: column index in the low bits, row index above it.
	localparam int XW     = $clog2(MAX_WIDTH);
	localparam int YW     = $clog2(MAX_HEIGHT);
	localparam int ADDR_W = XW + YW;
	localparam int DEPTH  = 1 << ADDR_W;

	// Largest usable source size, limited by the register width.
	localparam int SW_CAP = (MAX_WIDTH < 511) ? MAX_WIDTH : 511;
	localparam int SH_CAP = (MAX_HEIGHT < 511) ? MAX_HEIGHT : 511;
	localparam logic [REG_W-1:0] SW_CAP9 = REG_W'(SW_CAP);
	localparam logic [REG_W-1:0] SH_CAP9 = REG_W'(SH_CAP);

	// Sequencer codes.
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_MUL  = 2'd1;
	localparam logic [1:0] ST_DIV  = 2'd2;
	localparam logic [1:0] ST_RD   = 2'd3;

	localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(NUM_W - 1);

	logic [1:0]         state_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [REG_W-1:0]   src_width_q;
	logic [REG_W-1:0]   src_height_q;
	logic [REG_W-1:0]   dst_width_q;
	logic [REG_W-1:0]   dst_height_q;
	logic [COORD_W-1:0] dx_q;
	logic [COORD_W-1:0] dy_q;
	logic [REG_W-1:0]   sw_m1_q;
	logic [REG_W-1:0]   sh_m1_q;
	logic [REG_W-1:0]   dw_q;
	logic [REG_W-1:0]   dh_q;
	div_lane_t          lane_x_q;
	div_lane_t          lane_y_q;
	logic               done_q;
	logic               oor_q;
	logic [PIX_W-1:0]   rd_data_q;

	logic               accept;
	logic               cfg_write;
	logic               req_oor;
	logic               wr_in_store;
	logic [REG_W-1:0]   sw_m1;
	logic [REG_W-1:0]   sh_m1;
	logic [17:0]        prod_x;
	logic [17:0]        prod_y;
	logic [ADDR_W-1:0]  wr_addr;
	logic [ADDR_W-1:0]  rd_addr;

	logic [PIX_W-1:0]   mem [DEPTH];

	// Handshake decode.
	assign accept    = start && !busy;
	assign busy      = (state_q != ST_IDLE);
	assign cfg_write = psel && penable && pwrite && pready;
	assign pready    = 1'b1;

	// Request range check and write range check against the store size.
	assign req_oor     = ({1'b0, dst_x} >= dst_width_q) || ({1'b0, dst_y} >= dst_height_q);
	assign wr_in_store = (32'(src_x) < MAX_WIDTH) && (32'(src_y) < MAX_HEIGHT);
	assign wr_addr     = {YW'(src_y), XW'(src_x)};

	// Source sizes less one, with zero taken as one and large values saturated.
	always_comb begin
		if (src_width_q == '0) begin
			sw_m1 = '0;
		end else if (src_width_q > SW_CAP9) begin
			sw_m1 = SW_CAP9 - REG_W'(1);
		end else begin
			sw_m1 = src_width_q - REG_W'(1);
		end
		if (src_height_q == '0) begin
			sh_m1 = '0;
		end else if (src_height_q > SH_CAP9) begin
			sh_m1 = SH_CAP9 - REG_W'(1);
		end else begin
			sh_m1 = src_height_q - REG_W'(1);
		end
	end

	// Numerator products (2d+1)*(n-1), one multiplier per axis.
	assign prod_x = 18'({dx_q, 1'b1}) * 18'(sw_m1_q);
	assign prod_y = 18'({dy_q, 1'b1}) * 18'(sh_m1_q);

	// Source address from the two quotients; each is below its source size.
	assign rd_addr = {lane_y_q.num[YW-1:0], lane_x_q.num[XW-1:0]};

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_width_q  <= REG_W'(256);
			src_height_q <= REG_W'(256);
			dst_width_q  <= REG_W'(256);
			dst_height_q <= REG_W'(256);
		end else if (cfg_write) begin
			case (paddr[3:2])
				REG_SRC_WIDTH:  src_width_q  <= pwdata[REG_W-1:0];
				REG_SRC_HEIGHT: src_height_q <= pwdata[REG_W-1:0];
				REG_DST_WIDTH:  dst_width_q  <= pwdata[REG_W-1:0];
				REG_DST_HEIGHT: dst_height_q <= pwdata[REG_W-1:0];
				default: ;
			endcase
		end
	end

	// Register read-back.
	always_comb begin
		case (paddr[3:2])
			REG_SRC_WIDTH:  prdata = 32'(src_width_q);
			REG_SRC_HEIGHT: prdata = 32'(src_height_q);
			REG_DST_WIDTH:  prdata = 32'(dst_width_q);
			REG_DST_HEIGHT: prdata = 32'(dst_height_q);
			default:        prdata = '0;
		endcase
	end

	// Sequencer and result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
			oor_q   <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept && opcode == OP_REQUEST) begin
						if (req_oor) begin
							done_q <= 1'b1;
							oor_q  <= 1'b1;
						end else begin
							state_q <= ST_MUL;
						end
					end
				end
				ST_MUL: begin
					cnt_q   <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == LAST_STEP) begin
						state_q <= ST_RD;
					end
				end
				ST_RD: begin
					done_q  <= 1'b1;
					oor_q   <= 1'b0;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Request operands and divider lanes.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && accept) begin
			dx_q    <= dst_x;
			dy_q    <= dst_y;
			sw_m1_q <= sw_m1;
			sh_m1_q <= sh_m1;
			dw_q    <= dst_width_q;
			dh_q    <= dst_height_q;
		end
		if (state_q == ST_MUL) begin
			lane_x_q.num <= NUM_W'(prod_x) + NUM_W'(dw_q);
			lane_x_q.rem <= '0;
			lane_x_q.div <= {dw_q, 1'b0};
			lane_y_q.num <= NUM_W'(prod_y) + NUM_W'(dh_q);
			lane_y_q.rem <= '0;
			lane_y_q.div <= {dh_q, 1'b0};
		end else if (state_q == ST_DIV) begin
			lane_x_q <= div_step(lane_x_q);
			lane_y_q <= div_step(lane_y_q);
		end
	end

	// Frame store: written on an accepted write word, read once per mapped request.
	always_ff @(posedge clk) begin
		if (accept && opcode == OP_WRITE && wr_in_store) begin
			mem[wr_addr] <= {pix_red, pix_green, pix_blue};
		end
		if (state_q == ST_RD) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	// Result word.
	assign done         = done_q;
	assign out_of_range = oor_q;
	assign out_blue     = oor_q ? 8'd0 : rd_data_q[7:0];
	assign out_green    = oor_q ? 8'd0 : rd_data_q[15:8];
	assign out_red      = oor_q ? 8'd0 : rd_data_q[23:16];

`ifndef NO_ASSERTIONS
	// A result word only follows a frame-store read or an out-of-range request.
	a_done_source: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(state_q == ST_RD || (accept && opcode == OP_REQUEST && req_oor)))
		else $error("result strobe without a finished request");

	// The block is back to idle whenever a result is shown.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy)
		else $error("result strobe while busy");

	// A write word never produces a result.
	a_write_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && opcode == OP_WRITE) |=> !done_q)
		else $error("write word produced a result");

	// An in-range request starts the multiply cycle.
	a_req_start: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && opcode == OP_REQUEST && !req_oor) |=> (state_q == ST_MUL))
		else $error("in-range request did not start the mapping");

	// The restoring divider keeps its remainders below the divisors.
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (lane_x_q.rem < lane_x_q.div && lane_y_q.rem < lane_y_q.div))
		else $error("divider remainder out of bound");
`endif

endmodule
